### hdl/lnfw_pkg.sv
`timescale 1ns / 1ps

package lnfw_pkg;

  localparam int MAG_W  = 32;
  localparam int DIV_W  = 30;
  localparam int CNT_W  = 6;
  localparam int SPAN_W = 4;
  localparam int BYTE_W = 8;
  localparam int QUOT_W = 8;

  localparam logic [CNT_W-1:0] FIRST_STEPS = CNT_W'(MAG_W);
  localparam logic [CNT_W-1:0] NEXT_STEPS  = CNT_W'(4);

  localparam logic [BYTE_W-1:0] LINE_TOP    = 8'd1;
  localparam logic [BYTE_W-1:0] LINE_BOTTOM = 8'd2;
  localparam logic [BYTE_W-1:0] CURSOR_TOP    = 8'h80;
  localparam logic [BYTE_W-1:0] CURSOR_BOTTOM = 8'hC0;
  localparam logic [BYTE_W-1:0] CURSOR_NONE   = 8'h00;
  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] HIGH_MASK   = 8'hF0;

  typedef enum logic [1:0] {
    REG_BACKLIGHT  = 2'd0,
    REG_ENABLE     = 2'd1,
    REG_DATA_SEL   = 2'd2,
    REG_CMD_SEL    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CURSOR,
    S_SIGN,
    S_DIV,
    S_DIGIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             first;
    logic [DIV_W-1:0] divisor;
  } div_cmd_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [SPAN_W-1:0] idx);
    logic [DIV_W-1:0] p;
    case (idx)
      4'd0:    p = DIV_W'(1);
      4'd1:    p = DIV_W'(10);
      4'd2:    p = DIV_W'(100);
      4'd3:    p = DIV_W'(1000);
      4'd4:    p = DIV_W'(10000);
      4'd5:    p = DIV_W'(100000);
      4'd6:    p = DIV_W'(1000000);
      4'd7:    p = DIV_W'(10000000);
      4'd8:    p = DIV_W'(100000000);
      4'd9:    p = DIV_W'(1000000000);
      default: p = DIV_W'(1);
    endcase
    return p;
  endfunction

endpackage

### hdl/lnfw_divider.sv
`timescale 1ns / 1ps

module lnfw_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  lnfw_pkg::div_cmd_t       cmd,
  input  logic [lnfw_pkg::MAG_W-1:0] dividend,
  output logic                     busy,
  output logic [lnfw_pkg::QUOT_W-1:0] quot
);
  import lnfw_pkg::*;

  logic [DIV_W-1:0] part;
  logic [MAG_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {part, dvd[MAG_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= cmd.first ? FIRST_STEPS : NEXT_STEPS;
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
    end
  end

  // one quotient bit per cycle; the remainder carries on to the next digit
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dsr  <= cmd.divisor;
      quot <= '0;
      if (cmd.first) begin
        part <= '0;
        dvd  <= dividend;
      end else begin
        part <= {4'b0, part[DIV_W-1:4]};
        dvd  <= {part[3:0], {(MAG_W-4){1'b0}}};
      end
    end else if (busy) begin
      part <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd  <= {dvd[MAG_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

### hdl/lcd_numeric_field_writer.sv
`timescale 1ns / 1ps

// Prints a signed number on an HD44780 LCD driven through an I2C port
// expander in 4-bit mode.
// in channel (in_valid/in_ready): value, digit_span, line_number, column.
// out channel (out_valid/out_ready): one transfer per LCD byte, carrying the
// six expander bytes for it. A number gives a cursor command, a '-' if it is
// negative, then min(digit_span, MAX_SPAN)+1 digits; last_of_run marks the
// final digit. cfg channel (cfg_valid/cfg_ready): cfg_index selects
// backlight, enable, data select or command select bits; ready is always
// high. One number at a time: after the input transfer the sequencer goes
// to S_CURSOR, which pushes the cursor byte into the output register once
// the output slot is free. Digits come from a shared divider that yields one
// quotient bit per cycle; the leading digit divides the whole magnitude,
// each further digit carries on from the remainder, and S_DIGIT pushes it.
// in_ready rises again the cycle after the last digit is loaded.
// The output register holds a byte until taken; while it is full and out_ready
// is low, pushing states wait. Reset empties the output and restores the register
// defaults (backlight 0x08, enable 0x04, data select 0x01, command 0x00).
module lcd_numeric_field_writer #(
  parameter int MAX_SPAN = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  input  logic [3:0]  digit_span,
  input  logic [7:0]  line_number,
  input  logic [7:0]  column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  high_plain,
  output logic [7:0]  high_strobe,
  output logic [7:0]  high_release,
  output logic [7:0]  low_plain,
  output logic [7:0]  low_strobe,
  output logic [7:0]  low_release,
  output logic [7:0]  lcd_byte,
  output logic        is_character,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lnfw_pkg::*;

  state_t state, state_next;

  logic [BYTE_W-1:0] backlight, enable, data_sel, cmd_sel;

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] idx;
  logic [BYTE_W-1:0] loc;

  logic [SPAN_W-1:0] span_sat;
  logic [BYTE_W-1:0] loc_in;
  logic              slot_free;
  logic              push;
  logic [BYTE_W-1:0] push_byte;
  logic              push_chr;
  logic              push_last;
  div_cmd_t          div_cmd;
  logic              div_busy;
  logic [QUOT_W-1:0] div_quot;
  logic [BYTE_W-1:0] sel, hi, lo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight <= 8'h08;
      enable    <= 8'h04;
      data_sel  <= 8'h01;
      cmd_sel   <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BACKLIGHT: backlight <= cfg_data;
        REG_ENABLE:    enable    <= cfg_data;
        REG_DATA_SEL:  data_sel  <= cfg_data;
        REG_CMD_SEL:   cmd_sel   <= cfg_data;
        default:       backlight <= backlight;
      endcase
    end
  end

  assign span_sat = (digit_span > SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN) : digit_span;

  always_comb begin
    case (line_number)
      LINE_TOP:    loc_in = CURSOR_TOP | {4'b0, column[3:0]};
      LINE_BOTTOM: loc_in = CURSOR_BOTTOM | {4'b0, column[3:0]};
      default:     loc_in = CURSOR_NONE;
    endcase
  end

  assign slot_free = !out_valid || out_ready;

  lnfw_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (mag),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_CURSOR;
      S_CURSOR: if (slot_free) state_next = neg ? S_SIGN : S_DIV;
      S_SIGN:   if (slot_free) state_next = S_DIV;
      S_DIV:    if (!div_busy) state_next = S_DIGIT;
      S_DIGIT:  if (slot_free) state_next = (idx == '0) ? S_IDLE : S_DIV;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    push            = 1'b0;
    push_byte       = loc;
    push_chr        = 1'b0;
    push_last       = 1'b0;
    div_cmd.start   = 1'b0;
    div_cmd.first   = 1'b1;
    div_cmd.divisor = pow10(span);
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_CURSOR: begin
        push          = slot_free;
        div_cmd.start = slot_free && !neg;
      end
      S_SIGN: begin
        push          = slot_free;
        push_byte     = ASCII_MINUS;
        push_chr      = 1'b1;
        div_cmd.start = slot_free;
      end
      S_DIGIT: begin
        push            = slot_free;
        push_byte       = ASCII_ZERO + div_quot;
        push_chr        = 1'b1;
        push_last       = (idx == '0);
        div_cmd.start   = slot_free && (idx != '0);
        div_cmd.first   = 1'b0;
        div_cmd.divisor = pow10(idx - SPAN_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      neg  <= value[MAG_W-1];
      mag  <= value[MAG_W-1] ? (MAG_W'(0) - value) : value;
      span <= span_sat;
      idx  <= span_sat;
      loc  <= loc_in;
    end else if (state == S_DIGIT && slot_free && idx != '0) begin
      idx <= idx - SPAN_W'(1);
    end
  end

  assign sel = push_chr ? data_sel : cmd_sel;
  assign hi  = sel | (push_byte & HIGH_MASK) | backlight;
  assign lo  = sel | {push_byte[3:0], 4'b0} | backlight;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      high_plain   <= hi;
      high_strobe  <= hi | enable;
      high_release <= hi & ~enable;
      low_plain    <= lo;
      low_strobe   <= lo | enable;
      low_release  <= lo & ~enable;
      lcd_byte     <= push_byte;
      is_character <= push_chr;
      last_of_run  <= push_last;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_busy)
    else $error("input taken while divider busy");
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    div_cmd.start |-> !div_busy)
    else $error("divider restarted while busy");
  a_accept_cursor: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CURSOR))
    else $error("accepted number did not start with cursor byte");
  a_last_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_run) |-> is_character)
    else $error("run ended on a command byte");
  a_digit_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> !div_busy)
    else $error("digit emitted before division finished");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lnfw_pkg::*;

  localparam int SPAN_LIMIT = 9;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 92;

  typedef struct packed {
    logic [7:0] high_plain;
    logic [7:0] high_strobe;
    logic [7:0] high_release;
    logic [7:0] low_plain;
    logic [7:0] low_strobe;
    logic [7:0] low_release;
    logic [7:0] lcd_byte;
    logic       is_character;
    logic       last_of_run;
  } lcd_xfer_t;

  typedef struct {
    logic [7:0] backlight;
    logic [7:0] enable;
    logic [7:0] data_sel;
    logic [7:0] cmd_sel;
  } expander_bits_t;

  // cursor and lead are typed-in expectations, used when known is set
  typedef struct packed {
    logic [31:0] number;
    logic [3:0]  span;
    logic [7:0]  line;
    logic [7:0]  col;
    logic        known;
    logic [7:0]  cursor;
    logic [7:0]  lead;
  } number_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value = '0;
  logic [3:0]  digit_span = '0;
  logic [7:0]  line_number = '0;
  logic [7:0]  column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  high_plain;
  logic [7:0]  high_strobe;
  logic [7:0]  high_release;
  logic [7:0]  low_plain;
  logic [7:0]  low_strobe;
  logic [7:0]  low_release;
  logic [7:0]  lcd_byte;
  logic        is_character;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  expander_bits_t expander_cfg = '{8'h08, 8'h04, 8'h01, 8'h00};
  lcd_xfer_t      pending_bytes[$];
  int             failures = 0;
  int             taken_count = 0;
  bit             quiet = 1'b0;
  bit             held_off = 1'b0;

  lcd_numeric_field_writer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .digit_span(digit_span),
    .line_number(line_number),
    .column(column),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .high_plain(high_plain),
    .high_strobe(high_strobe),
    .high_release(high_release),
    .low_plain(low_plain),
    .low_strobe(low_strobe),
    .low_release(low_release),
    .lcd_byte(lcd_byte),
    .is_character(is_character),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic lcd_xfer_t expander_bytes(input logic [7:0] b, input logic chr,
                                               input logic last);
    lcd_xfer_t  x;
    logic [7:0] sel;
    logic [7:0] hi;
    logic [7:0] lo;
    sel = chr ? expander_cfg.data_sel : expander_cfg.cmd_sel;
    hi = sel | (b & HIGH_MASK) | expander_cfg.backlight;
    lo = sel | {b[3:0], 4'h0} | expander_cfg.backlight;
    x.high_plain   = hi;
    x.high_strobe  = hi | expander_cfg.enable;
    x.high_release = hi & ~expander_cfg.enable;
    x.low_plain    = lo;
    x.low_strobe   = lo | expander_cfg.enable;
    x.low_release  = lo & ~expander_cfg.enable;
    x.lcd_byte     = b;
    x.is_character = chr;
    x.last_of_run  = last;
    return x;
  endfunction

  function automatic void predict_field(input number_row_t r);
    lcd_xfer_t   run[$];
    logic        neg;
    logic [31:0] mag;
    logic [31:0] divisor;
    logic [31:0] quot;
    logic [7:0]  loc;
    int          span;
    neg = r.number[31];
    mag = neg ? 32'd0 - r.number : r.number;
    span = (r.span > SPAN_LIMIT) ? SPAN_LIMIT : r.span;
    if (r.line == LINE_TOP) loc = CURSOR_TOP | {4'h0, r.col[3:0]};
    else if (r.line == LINE_BOTTOM) loc = CURSOR_BOTTOM | {4'h0, r.col[3:0]};
    else loc = CURSOR_NONE;
    run.push_back(expander_bytes(loc, 1'b0, 1'b0));
    if (neg) run.push_back(expander_bytes(ASCII_MINUS, 1'b1, 1'b0));
    divisor = 32'd1;
    for (int k = 0; k < span; k++) divisor = divisor * 32'd10;
    while (divisor != 0) begin
      quot = mag / divisor;
      mag = mag % divisor;
      run.push_back(expander_bytes(ASCII_ZERO + quot[7:0], 1'b1, divisor == 32'd1));
      divisor = divisor / 32'd10;
    end
    if (r.known) begin
      run[0] = expander_bytes(r.cursor, 1'b0, 1'b0);
      run[1] = expander_bytes(r.lead, 1'b1, run[1].last_of_run);
    end
    foreach (run[k]) pending_bytes.push_back(run[k]);
  endfunction

  task automatic offer_number(input number_row_t r);
    in_valid    <= 1'b1;
    value       <= r.number;
    digit_span  <= r.span;
    line_number <= r.line;
    column      <= r.col;
    do @(posedge clk); while (!in_ready);
    predict_field(r);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic write_registers(input expander_bits_t bits);
    cfg_reg_t r;
    r = REG_BACKLIGHT;
    cfg_valid <= 1'b1;
    repeat (4) begin
      cfg_index <= r;
      case (r)
        REG_BACKLIGHT: cfg_data <= bits.backlight;
        REG_ENABLE:    cfg_data <= bits.enable;
        REG_DATA_SEL:  cfg_data <= bits.data_sel;
        REG_CMD_SEL:   cfg_data <= bits.cmd_sel;
        default:       ;
      endcase
      do @(posedge clk); while (!cfg_ready);
      case (r)
        REG_BACKLIGHT: expander_cfg.backlight = bits.backlight;
        REG_ENABLE:    expander_cfg.enable    = bits.enable;
        REG_DATA_SEL:  expander_cfg.data_sel  = bits.data_sel;
        REG_CMD_SEL:   expander_cfg.cmd_sel   = bits.cmd_sel;
        default:       ;
      endcase
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic number_row_t random_number();
    number_row_t r;
    longint      range;
    r.span = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, SPAN_LIMIT));
    case ($urandom_range(0, 5))
      0: r.number = $urandom;
      1: r.number = $urandom_range(0, 999);
      2: begin
        range = 10;
        for (int k = 0; k < r.span && k < SPAN_LIMIT; k++) range = range * 10;
        r.number = 32'(longint'($urandom) % range);
      end
      3: begin
        case ($urandom_range(0, 5))
          0: r.number = 32'h0000_0000;
          1: r.number = 32'h7FFF_FFFF;
          2: r.number = 32'h8000_0000;
          3: r.number = 32'h8000_0001;
          4: r.number = 32'hFFFF_FFFF;
          default: r.number = 32'h0000_0001;
        endcase
      end
      default: r.number = $urandom_range(0, 99999);
    endcase
    if ($urandom_range(0, 2) == 0) r.number = 32'd0 - r.number;
    r.line = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(1, 2));
    r.col = 8'($urandom_range(0, 255));
    r.known = 1'b0;
    r.cursor = '0;
    r.lead = '0;
    return r;
  endfunction

  task automatic check_byte(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    lcd_xfer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected transfer: lcd_byte %h", lcd_byte);
        failures++;
      end else begin
        want = pending_bytes.pop_front();
        check_byte("high_plain", want.high_plain, high_plain);
        check_byte("high_strobe", want.high_strobe, high_strobe);
        check_byte("high_release", want.high_release, high_release);
        check_byte("low_plain", want.low_plain, low_plain);
        check_byte("low_strobe", want.low_strobe, low_strobe);
        check_byte("low_release", want.low_release, low_release);
        check_byte("lcd_byte", want.lcd_byte, lcd_byte);
        check_byte("is_character", {7'b0, want.is_character}, {7'b0, is_character});
        check_byte("last_of_run", {7'b0, want.last_of_run}, {7'b0, last_of_run});
        taken_count++;
      end
    end
  end

  // LCD side: random stalls, one long hold-off to back the block up
  initial begin : lcd_sink
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_off && taken_count >= 150) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin : stimulus
    number_row_t    rows [22];
    expander_bits_t bits;
    rows = '{
      '{32'd0,          4'd0,  8'd1,   8'd0,   1'b1, CURSOR_TOP,           ASCII_ZERO},
      '{32'd5,          4'd0,  8'd2,   8'd15,  1'b1, 8'hCF,                ASCII_ZERO + 8'd5},
      '{-32'sd7,        4'd0,  8'd1,   8'd3,   1'b1, 8'h83,                ASCII_MINUS},
      '{32'h7FFF_FFFF,  4'd9,  8'd1,   8'd0,   1'b1, CURSOR_TOP,           ASCII_ZERO + 8'd2},
      '{32'h8000_0001,  4'd9,  8'd2,   8'd0,   1'b1, CURSOR_BOTTOM,        ASCII_MINUS},
      '{32'h8000_0000,  4'd9,  8'd1,   8'd1,   1'b1, 8'h81,                ASCII_MINUS},
      '{32'd123,        4'd0,  8'd1,   8'd0,   1'b1, CURSOR_TOP,           8'd171},
      '{32'h7FFF_FFFF,  4'd0,  8'd1,   8'd0,   1'b1, CURSOR_TOP,           8'd47},
      '{32'd12345,      4'd15, 8'd1,   8'd0,   1'b1, CURSOR_TOP,           ASCII_ZERO},
      '{32'd99,         4'd10, 8'd2,   8'd7,   1'b1, 8'hC7,                ASCII_ZERO},
      '{32'd0,          4'd0,  8'd0,   8'd5,   1'b1, CURSOR_NONE,          ASCII_ZERO},
      '{32'd0,          4'd0,  8'd3,   8'd5,   1'b1, CURSOR_NONE,          ASCII_ZERO},
      '{32'd0,          4'd0,  8'd255, 8'd255, 1'b1, CURSOR_NONE,          ASCII_ZERO},
      '{32'd1,          4'd1,  8'd1,   8'hF5,  1'b1, 8'h85,                ASCII_ZERO},
      '{32'd42,         4'd1,  8'd2,   8'h1A,  1'b1, 8'hCA,                ASCII_ZERO + 8'd4},
      '{-32'sd1,        4'd2,  8'd1,   8'd0,   1'b1, CURSOR_TOP,           ASCII_MINUS},
      '{32'd1000000000, 4'd9,  8'd1,   8'd0,   1'b1, CURSOR_TOP,           ASCII_ZERO + 8'd1},
      '{32'hFFFF_FFFF,  4'd9,  8'd2,   8'd9,   1'b1, 8'hC9,                ASCII_MINUS},
      '{32'd7,          4'd3,  8'd1,   8'd8,   1'b0, 8'h00,                8'h00},
      '{32'd987654321,  4'd8,  8'd2,   8'd2,   1'b0, 8'h00,                8'h00},
      '{-32'sd100000,   4'd5,  8'd1,   8'd12,  1'b0, 8'h00,                8'h00},
      '{32'd55,         4'd4,  8'd128, 8'd0,   1'b0, 8'h00,                8'h00}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) offer_number(rows[k]);

    for (int phase = 0; phase < PHASES; phase++) begin
      in_valid <= 1'b0;
      wait (pending_bytes.size() == 0);
      @(posedge clk);
      repeat (10) @(posedge clk);
      case (phase)
        0: bits = '{8'h00, 8'h00, 8'h00, 8'h00};
        1: bits = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        4: bits = '{8'h08, 8'h04, 8'h01, 8'h00};
        default: bits = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      write_registers(bits);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == PHASES - 1 && i >= 40) quiet = 1'b1;
        offer_number(random_number());
      end
    end

    in_valid <= 1'b0;
    wait (pending_bytes.size() == 0);
    repeat (100) @(posedge clk);
    if (failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### lcd_numeric_field_writer.f
hdl/lnfw_pkg.sv
hdl/lnfw_divider.sv
hdl/lcd_numeric_field_writer.sv
tb/sv/testbench.sv
